// ----- hw/rtl/pprc_pkg.sv -----
// ============================================================================
// pprc_pkg
// Shared types, widths and helpers for the particle pair collision response
// pipeline: request/result payloads, the context that rides the pipeline and
// the output clamp.
// ============================================================================
package pprc_pkg;

    // field widths
    localparam int POS_W   = 24;
    localparam int RAD_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int DIFF_W  = POS_W + 1;

    // square root: radicand is (dx^2 + dy^2) << 14 limited to 48 bits
    localparam int SQ_X_W    = 48;
    localparam int DIST_W    = 24;
    localparam int SQ_STEPS  = DIST_W;

    // normal division: |d| << 23 over distance, quotient up to 65536
    localparam int DIV_N_W   = 47;
    localparam int DIV_STEPS = 17;
    localparam int NORM_W    = DIV_STEPS + 1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
    localparam logic signed [NORM_W-1:0] NORM_ONE = 18'sd65536;

    localparam logic signed [31:0] POS_MAX = 32'sd8388607;
    localparam logic signed [31:0] POS_MIN = -32'sd8388608;

    // configuration register indexes
    typedef enum logic {
        CFG_SEP_GAIN      = 1'b0,
        CFG_PARTICLE_MASS = 1'b1
    } pprc_cfg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0] first_pos_x;
        logic signed [POS_W-1:0] first_pos_y;
        logic signed [POS_W-1:0] first_vel_x;
        logic signed [POS_W-1:0] first_vel_y;
        logic        [RAD_W-1:0] first_radius;
        logic signed [POS_W-1:0] second_pos_x;
        logic signed [POS_W-1:0] second_pos_y;
        logic signed [POS_W-1:0] second_vel_x;
        logic signed [POS_W-1:0] second_vel_y;
        logic        [RAD_W-1:0] second_radius;
        logic        [1:0]       resting_flags;
    } pprc_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] new_first_pos_x;
        logic signed [POS_W-1:0] new_first_pos_y;
        logic signed [POS_W-1:0] new_first_vel_x;
        logic signed [POS_W-1:0] new_first_vel_y;
        logic signed [POS_W-1:0] new_second_pos_x;
        logic signed [POS_W-1:0] new_second_pos_y;
        logic signed [POS_W-1:0] new_second_vel_x;
        logic signed [POS_W-1:0] new_second_vel_y;
        logic                    overlapping;
        logic                    impulse_applied;
        logic                    saturated;
    } pprc_out_t;

    // context that travels with each request through the pipeline
    typedef struct packed {
        pprc_in_t                 item;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic                     far;
        logic        [DIST_W-1:0] distance;
        logic        [DIST_W-1:0] overlap;
        logic                     ovl;
    } pprc_ctx_t;

    // clamp to the 24-bit range, msb of the result flags a clamp
    function automatic logic [POS_W:0] clamp_pos(input logic signed [31:0] v);
        logic [POS_W:0] r;
        if (v > POS_MAX)
        begin
            r = {1'b1, POS_MAX[POS_W-1:0]};
        end
        else if (v < POS_MIN)
        begin
            r = {1'b1, POS_MIN[POS_W-1:0]};
        end
        else
        begin
            r = {1'b0, v[POS_W-1:0]};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/pprc_sqrt_pipe.sv -----
// ============================================================================
// pprc_sqrt_pipe
// Pipelined integer square root, one result bit per stage, floor rounding.
// ============================================================================
module pprc_sqrt_pipe
    import pprc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    input  logic [SQ_X_W-1:0] radicand,
    input  pprc_ctx_t         ctx,
    output logic              root_valid,
    output logic [DIST_W-1:0] root,
    output pprc_ctx_t         root_ctx
);

    logic [SQ_X_W-1:0] rem_reg  [SQ_STEPS];
    logic [DIST_W-1:0] root_reg [SQ_STEPS];
    pprc_ctx_t         ctx_reg  [SQ_STEPS];
    logic [SQ_STEPS-1:0] vld_reg;

    logic [SQ_X_W-1:0] rem_cur  [SQ_STEPS];
    logic [DIST_W-1:0] root_cur [SQ_STEPS];
    pprc_ctx_t         ctx_cur  [SQ_STEPS];
    logic [SQ_X_W+1:0] trial    [SQ_STEPS];
    logic [SQ_STEPS-1:0] take;

    // stage inputs and trial subtrahend (2*root*2^b + 4^b)
    always_comb
    begin
        rem_cur[0]  = radicand;
        root_cur[0] = '0;
        ctx_cur[0]  = ctx;
        for (int k = 1; k < SQ_STEPS; k++)
        begin
            rem_cur[k]  = rem_reg[k-1];
            root_cur[k] = root_reg[k-1];
            ctx_cur[k]  = ctx_reg[k-1];
        end
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            trial[k] = ((SQ_X_W+2)'(root_cur[k]) << (SQ_STEPS - k))
                     | ((SQ_X_W+2)'(1) << (2 * (SQ_STEPS - 1 - k)));
            take[k]  = {2'b00, rem_cur[k]} >= trial[k];
        end
    end

    // valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[SQ_STEPS-2:0], valid};
        end
    end

    // one root bit per stage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            rem_reg[k]  <= take[k] ? rem_cur[k] - trial[k][SQ_X_W-1:0] : rem_cur[k];
            root_reg[k] <= take[k] ? root_cur[k] | (DIST_W'(1) << (SQ_STEPS - 1 - k))
                                   : root_cur[k];
            ctx_reg[k]  <= ctx_cur[k];
        end
    end

    assign root_valid = vld_reg[SQ_STEPS-1];
    assign root       = root_reg[SQ_STEPS-1];
    assign root_ctx   = ctx_reg[SQ_STEPS-1];

endmodule

// ----- hw/rtl/pprc_div_pipe.sv -----
// ============================================================================
// pprc_div_pipe
// Pipelined restoring divider for both normal components, one quotient bit
// per stage, unsigned magnitudes, truncating.
// ============================================================================
module pprc_div_pipe
    import pprc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    input  logic [DIV_N_W-1:0]   num_x,
    input  logic [DIV_N_W-1:0]   num_y,
    input  logic [DIST_W-1:0]    divisor,
    input  pprc_ctx_t            ctx,
    output logic                 quo_valid,
    output logic [DIV_STEPS-1:0] quo_x,
    output logic [DIV_STEPS-1:0] quo_y,
    output pprc_ctx_t            quo_ctx
);

    logic [DIV_N_W-1:0]   remx_reg [DIV_STEPS];
    logic [DIV_N_W-1:0]   remy_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] qx_reg   [DIV_STEPS];
    logic [DIV_STEPS-1:0] qy_reg   [DIV_STEPS];
    logic [DIST_W-1:0]    den_reg  [DIV_STEPS];
    pprc_ctx_t            ctx_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;

    logic [DIV_N_W-1:0]   remx_cur [DIV_STEPS];
    logic [DIV_N_W-1:0]   remy_cur [DIV_STEPS];
    logic [DIV_STEPS-1:0] qx_cur   [DIV_STEPS];
    logic [DIV_STEPS-1:0] qy_cur   [DIV_STEPS];
    logic [DIST_W-1:0]    den_cur  [DIV_STEPS];
    pprc_ctx_t            ctx_cur  [DIV_STEPS];
    logic [DIV_N_W-1:0]   trial    [DIV_STEPS];
    logic [DIV_STEPS-1:0] take_x;
    logic [DIV_STEPS-1:0] take_y;

    // stage inputs and shifted divisor
    always_comb
    begin
        remx_cur[0] = num_x;
        remy_cur[0] = num_y;
        qx_cur[0]   = '0;
        qy_cur[0]   = '0;
        den_cur[0]  = divisor;
        ctx_cur[0]  = ctx;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            remx_cur[k] = remx_reg[k-1];
            remy_cur[k] = remy_reg[k-1];
            qx_cur[k]   = qx_reg[k-1];
            qy_cur[k]   = qy_reg[k-1];
            den_cur[k]  = den_reg[k-1];
            ctx_cur[k]  = ctx_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial[k]  = DIV_N_W'(den_cur[k]) << (DIV_STEPS - 1 - k);
            take_x[k] = remx_cur[k] >= trial[k];
            take_y[k] = remy_cur[k] >= trial[k];
        end
    end

    // valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], valid};
        end
    end

    // one quotient bit per stage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            remx_reg[k] <= take_x[k] ? remx_cur[k] - trial[k] : remx_cur[k];
            remy_reg[k] <= take_y[k] ? remy_cur[k] - trial[k] : remy_cur[k];
            qx_reg[k]   <= qx_cur[k] | (DIV_STEPS'(take_x[k]) << (DIV_STEPS - 1 - k));
            qy_reg[k]   <= qy_cur[k] | (DIV_STEPS'(take_y[k]) << (DIV_STEPS - 1 - k));
            den_reg[k]  <= den_cur[k];
            ctx_reg[k]  <= ctx_cur[k];
        end
    end

    assign quo_valid = vld_reg[DIV_STEPS-1];
    assign quo_x     = qx_reg[DIV_STEPS-1];
    assign quo_y     = qy_reg[DIV_STEPS-1];
    assign quo_ctx   = ctx_reg[DIV_STEPS-1];

endmodule

// ----- hw/rtl/pprc_resp.sv -----
// ============================================================================
// pprc_resp
// Response back end: signed normal, push-apart, normal velocity, impulse,
// final sums and clamping, six register stages.
// ============================================================================
module pprc_resp
    import pprc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    input  logic [DIV_STEPS-1:0] quo_x,
    input  logic [DIV_STEPS-1:0] quo_y,
    input  pprc_ctx_t            ctx,
    input  logic [GAIN_W-1:0]    gain,
    output logic                 done,
    output pprc_out_t            result
);

    logic [5:0] vld_reg;

    // stage 1
    pprc_ctx_t                c1_reg;
    logic signed [NORM_W-1:0] nx1_reg, ny1_reg;
    logic signed [DIFF_W-1:0] rvx1_reg, rvy1_reg;
    logic [DIST_W+GAIN_W-1:0] og1_reg;
    logic signed [NORM_W-1:0] nx1_next, ny1_next;
    logic signed [DIFF_W-1:0] rvx1_next, rvy1_next;

    // stage 2
    pprc_ctx_t                c2_reg;
    logic signed [NORM_W-1:0] nx2_reg, ny2_reg;
    logic signed [58:0]       ppx2_reg, ppy2_reg;
    logic signed [42:0]       pvx2_reg, pvy2_reg;

    // stage 3
    pprc_ctx_t                c3_reg;
    logic signed [NORM_W-1:0] nx3_reg, ny3_reg;
    logic signed [26:0]       pushx3_reg, pushy3_reg;
    logic signed [43:0]       vn3_reg;
    logic signed [58:0]       rndx3, rndy3;

    // stage 4
    pprc_ctx_t                c4_reg;
    logic signed [26:0]       pushx4_reg, pushy4_reg;
    logic signed [61:0]       vnx4_reg, vny4_reg;
    logic                     neg4_reg;

    // stage 5
    pprc_ctx_t                c5_reg;
    logic signed [26:0]       pushx5_reg, pushy5_reg;
    logic signed [29:0]       dvx5_reg, dvy5_reg;
    logic                     imp5_reg;
    logic signed [63:0]       jx5, jy5;

    // stage 6
    pprc_out_t                result_reg;
    pprc_out_t                result_next;
    logic                     mv1, mv2;
    logic signed [31:0]       p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
    logic [POS_W:0]           c_p1x, c_p1y, c_v1x, c_v1y, c_p2x, c_p2y, c_v2x, c_v2y;

    // valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], valid};
        end
    end

    // signed normal, relative velocity; zero distance takes (1, 0)
    always_comb
    begin
        if (ctx.distance == '0)
        begin
            nx1_next = NORM_ONE;
            ny1_next = '0;
        end
        else
        begin
            nx1_next = ctx.dx[DIFF_W-1] ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
            ny1_next = ctx.dy[DIFF_W-1] ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
        end
        rvx1_next = DIFF_W'(ctx.item.first_vel_x) - DIFF_W'(ctx.item.second_vel_x);
        rvy1_next = DIFF_W'(ctx.item.first_vel_y) - DIFF_W'(ctx.item.second_vel_y);
    end

    always_ff @(posedge clk)
    begin
        c1_reg   <= ctx;
        nx1_reg  <= nx1_next;
        ny1_reg  <= ny1_next;
        rvx1_reg <= rvx1_next;
        rvy1_reg <= rvy1_next;
        og1_reg  <= ctx.overlap * gain;
    end

    // push products and velocity products
    always_ff @(posedge clk)
    begin
        c2_reg   <= c1_reg;
        nx2_reg  <= nx1_reg;
        ny2_reg  <= ny1_reg;
        ppx2_reg <= nx1_reg * $signed({1'b0, og1_reg});
        ppy2_reg <= ny1_reg * $signed({1'b0, og1_reg});
        pvx2_reg <= rvx1_reg * nx1_reg;
        pvy2_reg <= rvy1_reg * ny1_reg;
    end

    // push rounded to nearest, normal velocity
    always_comb
    begin
        rndx3 = ppx2_reg + 59'sd2147483648;
        rndy3 = ppy2_reg + 59'sd2147483648;
    end

    always_ff @(posedge clk)
    begin
        c3_reg     <= c2_reg;
        nx3_reg    <= nx2_reg;
        ny3_reg    <= ny2_reg;
        pushx3_reg <= rndx3[58:32];
        pushy3_reg <= rndy3[58:32];
        vn3_reg    <= 44'(pvx2_reg) + 44'(pvy2_reg);
    end

    // normal velocity projected back on the normal
    always_ff @(posedge clk)
    begin
        c4_reg     <= c3_reg;
        pushx4_reg <= pushx3_reg;
        pushy4_reg <= pushy3_reg;
        vnx4_reg   <= vn3_reg * nx3_reg;
        vny4_reg   <= vn3_reg * ny3_reg;
        neg4_reg   <= vn3_reg[43];
    end

    // impulse dv = round(-3 * vn * n / 2^34)
    always_comb
    begin
        jx5 = -((64'(vnx4_reg) <<< 1) + 64'(vnx4_reg)) + 64'sd8589934592;
        jy5 = -((64'(vny4_reg) <<< 1) + 64'(vny4_reg)) + 64'sd8589934592;
    end

    always_ff @(posedge clk)
    begin
        c5_reg     <= c4_reg;
        pushx5_reg <= pushx4_reg;
        pushy5_reg <= pushy4_reg;
        dvx5_reg   <= jx5[63:34];
        dvy5_reg   <= jy5[63:34];
        imp5_reg   <= c4_reg.ovl & neg4_reg;
    end

    // final sums and clamp
    always_comb
    begin
        mv1 = c5_reg.ovl & ~c5_reg.item.resting_flags[0];
        mv2 = c5_reg.ovl & ~c5_reg.item.resting_flags[1];
        p1x = 32'(c5_reg.item.first_pos_x)  + (mv1 ? 32'(pushx5_reg) : 32'sd0);
        p1y = 32'(c5_reg.item.first_pos_y)  + (mv1 ? 32'(pushy5_reg) : 32'sd0);
        p2x = 32'(c5_reg.item.second_pos_x) - (mv2 ? 32'(pushx5_reg) : 32'sd0);
        p2y = 32'(c5_reg.item.second_pos_y) - (mv2 ? 32'(pushy5_reg) : 32'sd0);
        v1x = 32'(c5_reg.item.first_vel_x)  + (imp5_reg ? 32'(dvx5_reg) : 32'sd0);
        v1y = 32'(c5_reg.item.first_vel_y)  + (imp5_reg ? 32'(dvy5_reg) : 32'sd0);
        v2x = 32'(c5_reg.item.second_vel_x) - (imp5_reg ? 32'(dvx5_reg) : 32'sd0);
        v2y = 32'(c5_reg.item.second_vel_y) - (imp5_reg ? 32'(dvy5_reg) : 32'sd0);
        c_p1x = clamp_pos(p1x);
        c_p1y = clamp_pos(p1y);
        c_v1x = clamp_pos(v1x);
        c_v1y = clamp_pos(v1y);
        c_p2x = clamp_pos(p2x);
        c_p2y = clamp_pos(p2y);
        c_v2x = clamp_pos(v2x);
        c_v2y = clamp_pos(v2y);
        result_next.new_first_pos_x  = c_p1x[POS_W-1:0];
        result_next.new_first_pos_y  = c_p1y[POS_W-1:0];
        result_next.new_first_vel_x  = c_v1x[POS_W-1:0];
        result_next.new_first_vel_y  = c_v1y[POS_W-1:0];
        result_next.new_second_pos_x = c_p2x[POS_W-1:0];
        result_next.new_second_pos_y = c_p2y[POS_W-1:0];
        result_next.new_second_vel_x = c_v2x[POS_W-1:0];
        result_next.new_second_vel_y = c_v2y[POS_W-1:0];
        result_next.overlapping      = c5_reg.ovl;
        result_next.impulse_applied  = imp5_reg;
        result_next.saturated        = c_p1x[POS_W] | c_p1y[POS_W] | c_v1x[POS_W]
                                     | c_v1y[POS_W] | c_p2x[POS_W] | c_p2y[POS_W]
                                     | c_v2x[POS_W] | c_v2y[POS_W];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = vld_reg[5];
    assign result = result_reg;

endmodule

// ----- hw/rtl/particle_pair_collision_response_core.sv -----
// ============================================================================
// particle_pair_collision_response_core
// Overlap test and equal-mass impulse response for a pair of circles.
// ============================================================================
// A request is taken on every cycle that start is high (busy stays low), and
// its result appears with done, one result per request in request order; the
// result is on the ports for that one cycle only and must be captured then.
// The pipeline is made of the 24-stage square root and the 17-stage normal
// divider, plus four input stages, one overlap stage and six response stages.
// Configuration writes take effect at once and are meant to be made only
// while no request is in flight.
module particle_pair_collision_response_core
    import pprc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pprc_in_t          req,
    output logic              done,
    output pprc_out_t         result,
    input  logic              cfg_wr_en,
    input  pprc_cfg_idx_t     cfg_index,
    input  logic [GAIN_W-1:0] cfg_data
);

    logic [GAIN_W-1:0] gain_reg;

    logic [3:0]         vld_reg;
    pprc_in_t           item0_reg;
    pprc_ctx_t          ctx1_reg, ctx2_reg, ctx3_reg, ctx1_next, ctx3_next;
    logic [SQ_X_W-1:0]  sqx2_reg, sqy2_reg;
    logic [SQ_X_W-1:0]  rad3_reg;
    logic [SQ_X_W:0]    sum_sq;
    logic signed [49:0] sqx_full, sqy_full;

    logic               sq_valid;
    logic [DIST_W-1:0]  sq_root;
    pprc_ctx_t          sq_ctx;

    logic               ovl_vld_reg;
    pprc_ctx_t          ctx4_reg, ctx4_next;
    logic signed [25:0] ovl_diff;
    logic [DIFF_W-1:0]  adx, ady;

    logic                 dv_valid;
    logic [DIV_STEPS-1:0] dv_qx, dv_qy;
    pprc_ctx_t            dv_ctx;

    // the pipeline never holds off a request
    assign busy = 1'b0;

    // configuration; mass cancels in the equal-mass impulse and is not kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SEP_GAIN:
                begin
                    gain_reg <= cfg_data;
                end
                CFG_PARTICLE_MASS:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // front-end valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            ovl_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[2:0], start & ~busy};
            ovl_vld_reg <= sq_valid;
        end
    end

    // position difference
    always_comb
    begin
        ctx1_next         = '0;
        ctx1_next.item    = item0_reg;
        ctx1_next.dx      = DIFF_W'(item0_reg.first_pos_x) - DIFF_W'(item0_reg.second_pos_x);
        ctx1_next.dy      = DIFF_W'(item0_reg.first_pos_y) - DIFF_W'(item0_reg.second_pos_y);
    end

    // squares, then sum; beyond 2^34 the circles cannot touch
    always_comb
    begin
        sqx_full      = ctx1_reg.dx * ctx1_reg.dx;
        sqy_full      = ctx1_reg.dy * ctx1_reg.dy;
        sum_sq        = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
        ctx3_next     = ctx2_reg;
        ctx3_next.far = |sum_sq[SQ_X_W:34];
    end

    always_ff @(posedge clk)
    begin
        item0_reg    <= req;
        ctx1_reg     <= ctx1_next;
        ctx2_reg     <= ctx1_reg;
        sqx2_reg     <= sqx_full[SQ_X_W-1:0];
        sqy2_reg     <= sqy_full[SQ_X_W-1:0];
        ctx3_reg     <= ctx3_next;
        rad3_reg     <= {sum_sq[33:0], 14'b0};
    end

    pprc_sqrt_pipe u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (vld_reg[3]),
        .radicand   (rad3_reg),
        .ctx        (ctx3_reg),
        .root_valid (sq_valid),
        .root       (sq_root),
        .root_ctx   (sq_ctx)
    );

    // overlap = (r1 + r2) * 128 - distance
    always_comb
    begin
        ovl_diff           = $signed({2'b00, 17'(sq_ctx.item.first_radius)
                                      + 17'(sq_ctx.item.second_radius), 7'b0})
                           - $signed({2'b00, sq_root});
        ctx4_next          = sq_ctx;
        ctx4_next.distance = sq_root;
        ctx4_next.overlap  = ovl_diff[DIST_W-1:0];
        ctx4_next.ovl      = ~sq_ctx.far & ~ovl_diff[25];
    end

    always_ff @(posedge clk)
    begin
        ctx4_reg <= ctx4_next;
    end

    // magnitudes for the normal division
    always_comb
    begin
        adx = ctx4_reg.dx[DIFF_W-1] ? DIFF_W'(-ctx4_reg.dx) : DIFF_W'(ctx4_reg.dx);
        ady = ctx4_reg.dy[DIFF_W-1] ? DIFF_W'(-ctx4_reg.dy) : DIFF_W'(ctx4_reg.dy);
    end

    pprc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (ovl_vld_reg),
        .num_x     ({adx[POS_W-1:0], 23'b0}),
        .num_y     ({ady[POS_W-1:0], 23'b0}),
        .divisor   (ctx4_reg.distance),
        .ctx       (ctx4_reg),
        .quo_valid (dv_valid),
        .quo_x     (dv_qx),
        .quo_y     (dv_qy),
        .quo_ctx   (dv_ctx)
    );

    pprc_resp u_resp (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (dv_valid),
        .quo_x  (dv_qx),
        .quo_y  (dv_qy),
        .ctx    (dv_ctx),
        .gain   (gain_reg),
        .done   (done),
        .result (result)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the particle pair collision response core. Pairs are
// sent through the command port and every result is compared field by field
// with a bit-exact fixed-point prediction. Runs go through several register
// settings and several amounts of idle time on the request side.
// ----------------------------------------------------------------------------
module tb
    import pprc_pkg::*;
();

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    pprc_in_t          req;
    logic              done;
    pprc_out_t         result;
    logic              cfg_wr_en;
    pprc_cfg_idx_t     cfg_index;
    logic [GAIN_W-1:0] cfg_data;

    localparam int LATENCY    = 52;
    localparam int WATCHDOG   = 4000;

    pprc_out_t         pending_results[$];
    logic [GAIN_W-1:0] gain_now;
    int                error_count;
    int                quiet_cycles;
    int                gap_pct;

    particle_pair_collision_response_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // integer square root, floor
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // divide by 2^s, round to nearest with ties up
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [POS_W-1:0] clamp24(input longint v, inout logic sat);
        if (v > 64'sd8388607)
        begin
            sat = 1'b1;
            return 24'h7FFFFF;
        end
        if (v < -64'sd8388608)
        begin
            sat = 1'b1;
            return 24'h800000;
        end
        return v[POS_W-1:0];
    endfunction

    // expected response for one pair
    function automatic pprc_out_t collide(input pprc_in_t a, input logic [GAIN_W-1:0] gain);
        longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
        longint dx, dy, distance, overlap, nx, ny, push_x, push_y, vn, j, dvx, dvy;
        longint unsigned sq;
        pprc_out_t o;
        logic sat;
        p1x = a.first_pos_x;   p1y = a.first_pos_y;
        v1x = a.first_vel_x;   v1y = a.first_vel_y;
        p2x = a.second_pos_x;  p2y = a.second_pos_y;
        v2x = a.second_vel_x;  v2y = a.second_vel_y;
        sat = 1'b0;
        o = '0;
        dx = p1x - p2x;
        dy = p1y - p2y;
        sq = longint'(dx * dx) + longint'(dy * dy);
        distance = longint'(floor_sqrt(sq << 14));
        overlap = (longint'(a.first_radius) + longint'(a.second_radius)) * 128 - distance;
        if (overlap >= 0)
        begin
            o.overlapping = 1'b1;
            nx = 65536;
            ny = 0;
            if (distance != 0)
            begin
                nx = (dx * 8388608) / distance;
                ny = (dy * 8388608) / distance;
            end
            push_x = round_shift(nx * overlap * longint'(gain), 32);
            push_y = round_shift(ny * overlap * longint'(gain), 32);
            if (!a.resting_flags[0])
            begin
                p1x += push_x;
                p1y += push_y;
            end
            if (!a.resting_flags[1])
            begin
                p2x -= push_x;
                p2y -= push_y;
            end
            vn = (v1x - v2x) * nx + (v1y - v2y) * ny;
            if (vn < 0)
            begin
                j = -3 * vn;
                dvx = round_shift(j * nx, 34);
                dvy = round_shift(j * ny, 34);
                o.impulse_applied = 1'b1;
                v1x += dvx;  v1y += dvy;
                v2x -= dvx;  v2y -= dvy;
            end
        end
        o.new_first_pos_x  = clamp24(p1x, sat);
        o.new_first_pos_y  = clamp24(p1y, sat);
        o.new_first_vel_x  = clamp24(v1x, sat);
        o.new_first_vel_y  = clamp24(v1y, sat);
        o.new_second_pos_x = clamp24(p2x, sat);
        o.new_second_pos_y = clamp24(p2y, sat);
        o.new_second_vel_x = clamp24(v2x, sat);
        o.new_second_vel_y = clamp24(v2y, sat);
        o.saturated = sat;
        return o;
    endfunction

    function automatic pprc_in_t make_pair(input int p1x, p1y, v1x, v1y, r1,
                                           input int p2x, p2y, v2x, v2y, r2, rest);
        pprc_in_t a;
        a.first_pos_x   = p1x[23:0];  a.first_pos_y  = p1y[23:0];
        a.first_vel_x   = v1x[23:0];  a.first_vel_y  = v1y[23:0];
        a.first_radius  = r1[15:0];
        a.second_pos_x  = p2x[23:0];  a.second_pos_y = p2y[23:0];
        a.second_vel_x  = v2x[23:0];  a.second_vel_y = v2y[23:0];
        a.second_radius = r2[15:0];
        a.resting_flags = rest[1:0];
        return a;
    endfunction

    // random pair: mostly close enough to touch, some fully random
    function automatic pprc_in_t random_pair();
        pprc_in_t a;
        int reach, offx, offy, r1, r2;
        a = pprc_in_t'($bits(pprc_in_t)'({$urandom, $urandom, $urandom, $urandom,
                                          $urandom, $urandom, $urandom, $urandom}));
        if ($urandom_range(99) < 80)
        begin
            r1 = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2048);
            r2 = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2048);
            reach = (r1 + r2) * 5 / 4 + 1;
            offx = $urandom_range(2 * reach) - reach;
            offy = $urandom_range(2 * reach) - reach;
            if ($urandom_range(9) == 0)
                offy = 0;
            a.first_radius  = r1[15:0];
            a.second_radius = r2[15:0];
            a.second_pos_x  = a.first_pos_x + offx[23:0];
            a.second_pos_y  = a.first_pos_y + offy[23:0];
            if ($urandom_range(1))
            begin
                a.first_vel_x  = 24'($urandom_range(8191) - 4096);
                a.first_vel_y  = 24'($urandom_range(8191) - 4096);
                a.second_vel_x = 24'($urandom_range(8191) - 4096);
                a.second_vel_y = 24'($urandom_range(8191) - 4096);
            end
        end
        return a;
    endfunction

    // send one request and record its expected result
    task automatic send_request(input pprc_in_t a);
        @(negedge clk);
        start <= 1'b1;
        req   <= a;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(collide(a, gain_now));
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain();
        idle_cycles(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        idle_cycles(LATENCY + 8);
    endtask

    task automatic write_reg(input pprc_cfg_idx_t idx, input logic [GAIN_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_SEP_GAIN)
            gain_now = val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed();
        // zero distance, approaching along x
        send_request(make_pair(1000, 2000, -300, 0, 256, 1000, 2000, 300, 0, 256, 0));
        // exact touch, overlap of zero
        send_request(make_pair(512, 0, -100, 0, 256, 0, 0, 100, 0, 256, 0));
        // clearly apart
        send_request(make_pair(100000, 5, 7, 9, 256, 0, 0, 3, 4, 256, 0));
        // overlapping and separating
        send_request(make_pair(300, 100, 500, 50, 512, 0, 0, -500, 0, 512, 0));
        // each resting combination
        for (int r = 0; r < 4; r++)
            send_request(make_pair(200, -150, -800, 600, 400, -100, 120, 700, -500, 300, r));
        // pushed past the positive limit
        send_request(make_pair(8388607, 8388607, 8388607, 8388607, 65535,
                               8388000, 8388500, -8388608, -8388608, 65535, 0));
        // pushed past the negative limit
        send_request(make_pair(-8388608, -8388608, -8388608, -8388608, 65535,
                               -8388000, -8388300, 8388607, 8388607, 65535, 0));
        // extremes far apart, no contact
        send_request(make_pair(8388607, -8388608, 8388607, -8388608, 65535,
                               -8388608, 8388607, -8388608, 8388607, 65535, 3));
        // zero radii at the same point
        send_request(make_pair(0, 0, 5, 0, 0, 0, 0, -5, 0, 0, 0));
        // zero radii apart
        send_request(make_pair(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // diagonal, large radii, fast approach
        send_request(make_pair(-20000, -20000, 3000000, 3000000, 65535,
                               20000, 20000, -3000000, -3000000, 65535, 0));
        drain();
    endtask

    task automatic test_random(input int count, input int pct);
        for (int i = 0; i < count; i++)
        begin
            send_request(random_pair());
            if ($urandom_range(99) < pct)
                idle_cycles($urandom_range(6, 1));
        end
        drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        pprc_out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.new_first_pos_x !== want.new_first_pos_x)
                begin
                    $error("new_first_pos_x exp %0d got %0d",
                           want.new_first_pos_x, result.new_first_pos_x);
                    error_count++;
                end
                if (result.new_first_pos_y !== want.new_first_pos_y)
                begin
                    $error("new_first_pos_y exp %0d got %0d",
                           want.new_first_pos_y, result.new_first_pos_y);
                    error_count++;
                end
                if (result.new_first_vel_x !== want.new_first_vel_x)
                begin
                    $error("new_first_vel_x exp %0d got %0d",
                           want.new_first_vel_x, result.new_first_vel_x);
                    error_count++;
                end
                if (result.new_first_vel_y !== want.new_first_vel_y)
                begin
                    $error("new_first_vel_y exp %0d got %0d",
                           want.new_first_vel_y, result.new_first_vel_y);
                    error_count++;
                end
                if (result.new_second_pos_x !== want.new_second_pos_x)
                begin
                    $error("new_second_pos_x exp %0d got %0d",
                           want.new_second_pos_x, result.new_second_pos_x);
                    error_count++;
                end
                if (result.new_second_pos_y !== want.new_second_pos_y)
                begin
                    $error("new_second_pos_y exp %0d got %0d",
                           want.new_second_pos_y, result.new_second_pos_y);
                    error_count++;
                end
                if (result.new_second_vel_x !== want.new_second_vel_x)
                begin
                    $error("new_second_vel_x exp %0d got %0d",
                           want.new_second_vel_x, result.new_second_vel_x);
                    error_count++;
                end
                if (result.new_second_vel_y !== want.new_second_vel_y)
                begin
                    $error("new_second_vel_y exp %0d got %0d",
                           want.new_second_vel_y, result.new_second_vel_y);
                    error_count++;
                end
                if (result.overlapping !== want.overlapping)
                begin
                    $error("overlapping exp %0b got %0b",
                           want.overlapping, result.overlapping);
                    error_count++;
                end
                if (result.impulse_applied !== want.impulse_applied)
                begin
                    $error("impulse_applied exp %0b got %0b",
                           want.impulse_applied, result.impulse_applied);
                    error_count++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $error("saturated exp %0b got %0b", want.saturated, result.saturated);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        error_count  = 0;
        quiet_cycles = 0;
        gain_now     = GAIN_RESET;
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_SEP_GAIN;
        cfg_data     = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(150, 0);

        write_reg(CFG_SEP_GAIN, 16'd0);
        write_reg(CFG_PARTICLE_MASS, 16'd1);
        test_directed();
        test_random(150, 80);

        write_reg(CFG_SEP_GAIN, 16'hFFFF);
        write_reg(CFG_PARTICLE_MASS, 16'hFFFF);
        test_directed();
        test_random(150, 18);

        write_reg(CFG_SEP_GAIN, 16'($urandom_range(1023)));
        write_reg(CFG_PARTICLE_MASS, 16'($urandom_range(65535, 1)));
        test_random(175, 0);
        write_reg(CFG_SEP_GAIN, 16'($urandom_range(65535)));
        test_random(175, 80);

        idle_cycles(LATENCY + 8);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pprc_pkg.sv
hw/rtl/pprc_sqrt_pipe.sv
hw/rtl/pprc_div_pipe.sv
hw/rtl/pprc_resp.sv
hw/rtl/particle_pair_collision_response_core.sv
bench/tb.sv
